@@ hw/rtl/word_repack_32_to_24_bitrev_macros.svh @@
// ----------------------------------------------------------------------------
// word_repack_32_to_24_bitrev assertion macros
// concurrent assertion wrappers for clocked implication checks on clk / rst_n
// ----------------------------------------------------------------------------
`ifndef WORD_REPACK_32_TO_24_BITREV_MACROS_SVH
`define WORD_REPACK_32_TO_24_BITREV_MACROS_SVH
`ifndef SYNTHESIS
`define WREP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrep check failed");
`define WREP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrep check failed");
`else
`define WREP_ASSERT_IMP(lbl, ante, cons)
`define WREP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/wrep_pkg.sv @@
// ----------------------------------------------------------------------------
// wrep_pkg
// beat types, phase codes and the 24-bit reversal shared by the repacker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wrep_pkg;

  localparam int unsigned SYM_BITS  = 24;
  localparam int unsigned BUF_DEPTH = 2;

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;
  localparam logic [1:0] PHASE_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] word;
    logic        frame_start;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_BITS-1:0] symbol;
    logic                last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic      two;
    out_beat_t first;
    out_beat_t second;
  } push_t;

  function automatic logic [SYM_BITS-1:0] reverse24(input logic [SYM_BITS-1:0] v);
    logic [SYM_BITS-1:0] r;
    for (int i = 0; i < SYM_BITS; i++) begin
      r[SYM_BITS-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/wrep_in_reg.sv @@
// ----------------------------------------------------------------------------
// wrep_in_reg
// input register: holds one word beat until the repacker takes it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrep_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wrep_pkg::in_beat_t in_beat,
  input  logic              take,
  output logic              a_valid,
  output wrep_pkg::in_beat_t a_beat
);

  logic               a_valid_r;
  logic               a_valid_nxt;
  wrep_pkg::in_beat_t a_beat_r;

  assign in_stall    = a_valid_r && !take;
  assign a_valid_nxt = in_stall ? a_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_beat_r <= in_beat;
    end
  end

  assign a_valid = a_valid_r;
  assign a_beat  = a_beat_r;

endmodule

@@ hw/rtl/wrep_repack.sv @@
// ----------------------------------------------------------------------------
// wrep_repack
// phase and leftover state; cuts one word into one or two reversed symbols
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrep_repack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  wrep_pkg::in_beat_t a_beat,
  output wrep_pkg::push_t    push
);

  logic [1:0]  phase_r;
  logic [1:0]  phase_nxt;
  logic [15:0] left_r;
  logic [15:0] left_nxt;
  logic [1:0]  p;
  logic [31:0] w;
  logic [23:0] s0;
  logic [23:0] s1;
  logic        two;

  assign w = a_beat.word;

  always_comb begin
    p = phase_r;
    if (a_beat.frame_start || phase_r == wrep_pkg::PHASE_UNUSED) begin
      p = wrep_pkg::PHASE_FIRST;
    end
    s1  = w[23:0];
    two = 1'b0;
    case (p)
      wrep_pkg::PHASE_SECOND: begin
        s0        = {left_r[7:0], w[31:16]};
        left_nxt  = w[15:0];
        phase_nxt = wrep_pkg::PHASE_THIRD;
      end
      wrep_pkg::PHASE_THIRD: begin
        s0        = {left_r, w[31:24]};
        left_nxt  = 16'd0;
        phase_nxt = wrep_pkg::PHASE_FIRST;
        two       = 1'b1;
      end
      default: begin
        s0        = w[31:8];
        left_nxt  = {8'd0, w[7:0]};
        phase_nxt = wrep_pkg::PHASE_SECOND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wrep_pkg::PHASE_FIRST;
      left_r  <= 16'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

  assign push.two                = two;
  assign push.first.symbol       = wrep_pkg::reverse24(s0);
  assign push.first.last_of_run  = 1'b0;
  assign push.second.symbol      = wrep_pkg::reverse24(s1);
  assign push.second.last_of_run = 1'b1;

endmodule

@@ hw/rtl/wrep_out_buf.sv @@
// ----------------------------------------------------------------------------
// wrep_out_buf
// two-entry symbol buffer; head entry drives the result port directly
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wrep_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  wrep_pkg::push_t     push,
  output logic [1:0]          space,
  output logic                out_valid,
  input  logic                out_stall,
  output wrep_pkg::out_beat_t out_beat
);

  logic [1:0]          cnt_r;
  logic [1:0]          cnt_nxt;
  wrep_pkg::out_beat_t e0_r;
  wrep_pkg::out_beat_t e0_nxt;
  wrep_pkg::out_beat_t e1_r;
  wrep_pkg::out_beat_t e1_nxt;
  logic                pop;

  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    case (cnt_r)
      2'd0:    space = 2'(wrep_pkg::BUF_DEPTH);
      2'd1:    space = pop ? 2'(wrep_pkg::BUF_DEPTH) : 2'(wrep_pkg::BUF_DEPTH - 1);
      default: space = pop ? 2'(wrep_pkg::BUF_DEPTH - 1) : 2'd0;
    endcase
  end

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      e0_nxt  = e1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
    if (fire) begin
      if (cnt_nxt == 2'd0) begin
        e0_nxt = push.first;
        e1_nxt = push.second;
      end else begin
        e1_nxt = push.first;
      end
      cnt_nxt = cnt_nxt + (push.two ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_beat  = e0_r;

endmodule

@@ hw/rtl/word_repack_32_to_24_bitrev.sv @@
// ----------------------------------------------------------------------------
// word_repack_32_to_24_bitrev
// 32-bit word stream to bit-reversed 24-bit symbol stream, 3 words -> 4 symbols
// ----------------------------------------------------------------------------
// A word beat is taken every cycle while the result buffer has room for its
// symbols; the word is registered, cut into one symbol (first and second
// word of a group) or two symbols (third word) and reversed, and the symbols
// go to a two-entry result buffer whose head entry drives the port. The
// result port moves one symbol per cycle while out_stall is low, which sets
// the sustained rate: a third word puts two symbols on the result port, so a
// full-rate stream takes three words per four symbols out. frame_start puts
// its word at the start of a group.
`timescale 1ns / 1ps

`include "word_repack_32_to_24_bitrev_macros.svh"

module word_repack_32_to_24_bitrev (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wrep_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output wrep_pkg::out_beat_t out_beat
);

  logic               a_valid;
  wrep_pkg::in_beat_t a_beat;
  wrep_pkg::push_t    push;
  logic [1:0]         space;
  logic               a_fire;

  assign a_fire = a_valid && (space >= (push.two ? 2'd2 : 2'd1));

  wrep_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .take     (a_fire),
    .a_valid  (a_valid),
    .a_beat   (a_beat)
  );

  wrep_repack u_repack (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (a_fire),
    .a_beat (a_beat),
    .push   (push)
  );

  wrep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (a_fire),
    .push      (push),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  `WREP_ASSERT_IMP(a_two_room, a_fire && push.two, space == 2'd2)
  `WREP_ASSERT_NXT(a_load, in_valid && !in_stall, a_valid)
  `WREP_ASSERT_IMP(a_hold, a_valid && !a_fire, in_stall)
  `WREP_ASSERT_NXT(a_fill_shows, a_fire && !out_valid, out_valid)

endmodule

@@ tb/sv/tb_word_repack_32_to_24_bitrev.sv @@
// ----------------------------------------------------------------------------
// tb_word_repack_32_to_24_bitrev
// self-checking bench for the 32-bit to bit-reversed 24-bit symbol repacker
// ----------------------------------------------------------------------------
// Word beats are sent in random bursts; an internal model of the group phase
// and carried bits predicts each symbol, and every result beat is checked in
// order against it. Directed words cover the data extremes and frame starts
// in every phase. The random part is mostly whole frames with some broken
// ones. The result side runs several stall patterns, including one long
// hold that backs the block up into its input.
`timescale 1ns / 1ps

module tb_word_repack_32_to_24_bitrev;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  wrep_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wrep_pkg::out_beat_t out_beat;

  wrep_pkg::out_beat_t exp_symbols[$];
  logic [1:0]          grp_phase = wrep_pkg::PHASE_FIRST;
  logic [15:0]         carry_bits = '0;

  int unsigned fail_count = 0;
  int unsigned burst_left = 0;
  int unsigned max_gap = 0;
  stall_mode_t stall_mode = STALL_NONE;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned stall_cyc = 0;

  word_repack_32_to_24_bitrev i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void report_fail(input string msg);
    if (fail_count < 10) begin
      $display("%0t: %s", $realtime, msg);
    end
    fail_count++;
  endfunction

  function automatic logic [23:0] flip24(input logic [23:0] v);
    logic [23:0] r;
    r = {<<{v}};
    return r;
  endfunction

  function automatic void predict_symbols(input wrep_pkg::in_beat_t b);
    logic [1:0]          ph;
    wrep_pkg::out_beat_t s0;
    wrep_pkg::out_beat_t s1;
    ph = b.frame_start ? wrep_pkg::PHASE_FIRST : grp_phase;
    s0.last_of_run = 1'b0;
    s1.last_of_run = 1'b1;
    case (ph)
      wrep_pkg::PHASE_SECOND: begin
        s0.symbol = flip24({carry_bits[7:0], b.word[31:16]});
        carry_bits = b.word[15:0];
        grp_phase = wrep_pkg::PHASE_THIRD;
        exp_symbols.push_back(s0);
      end
      wrep_pkg::PHASE_THIRD: begin
        s0.symbol = flip24({carry_bits, b.word[31:24]});
        s1.symbol = flip24(b.word[23:0]);
        carry_bits = '0;
        grp_phase = wrep_pkg::PHASE_FIRST;
        exp_symbols.push_back(s0);
        exp_symbols.push_back(s1);
      end
      default: begin
        s0.symbol = flip24(b.word[31:8]);
        carry_bits = {8'h00, b.word[7:0]};
        grp_phase = wrep_pkg::PHASE_SECOND;
        exp_symbols.push_back(s0);
      end
    endcase
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic send_word(input logic [31:0] w, input logic fs);
    wrep_pkg::in_beat_t b;
    int unsigned        gap;
    b.word = w;
    b.frame_start = fs;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (max_gap == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_gap);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    predict_symbols(b);
  endtask

  // receiver stall pattern, with a long hold on request
  always @(posedge clk) begin
    stall_cyc++;
    if (hold_cnt == 0 && hold_req) begin
      hold_cnt = 300;
      hold_req = 1'b0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 9) < 3);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 7);
        STALL_PERIODIC: out_stall <= ((stall_cyc % 7) < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : check_beats
    wrep_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_symbols.size() == 0) begin
        report_fail($sformatf("unexpected beat: symbol=%h last_of_run=%b",
                              out_beat.symbol, out_beat.last_of_run));
      end else begin
        want = exp_symbols.pop_front();
        if (out_beat.symbol !== want.symbol) begin
          report_fail($sformatf("symbol mismatch: expected %h actual %h",
                                want.symbol, out_beat.symbol));
        end
        if (out_beat.last_of_run !== want.last_of_run) begin
          report_fail($sformatf("last_of_run mismatch: expected %b actual %b",
                                want.last_of_run, out_beat.last_of_run));
        end
      end
    end
  end

  task automatic test_directed();
    max_gap = 0;
    stall_mode = STALL_NONE;
    // first group straight out of reset, no frame start
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'hffff_ffff, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hffff_ffff, 1'b0);
    send_word(32'haaaa_aaaa, 1'b1);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'h0123_4567, 1'b0);
    // frame start while in the second phase
    send_word(32'hdead_beef, 1'b1);
    send_word(32'hcafe_f00d, 1'b1);
    send_word(32'h0000_00ff, 1'b0);
    // frame start while in the third phase, stale carry dropped
    send_word(32'hff00_ff00, 1'b1);
    send_word(32'h00ff_00ff, 1'b0);
    send_word(32'h8000_0000, 1'b1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h7fff_ffff, 1'b0);
    // back to back frame starts
    send_word(32'hffff_ff00, 1'b1);
    send_word(32'h0000_00ff, 1'b1);
    send_word(32'h1234_5678, 1'b1);
    send_word(32'h9abc_def0, 1'b0);
    send_word(32'h0f0f_0f0f, 1'b0);
  endtask

  task automatic send_random_frames(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned sel;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(0, 9);
      len = (sel < 7) ? 3 * $urandom_range(1, 4) : $urandom_range(1, 5);
      for (int unsigned i = 0; i < len; i++) begin
        case (sel)
          8:       send_word($urandom, 1'($urandom_range(0, 1)));
          9:       send_word($urandom, 1'b0);
          default: send_word($urandom, (i == 0));
        endcase
      end
      sent += len;
    end
  endtask

  task automatic test_random_frames();
    max_gap = 4;
    stall_mode = STALL_LIGHT;
    send_random_frames(150);
  endtask

  task automatic test_full_rate();
    max_gap = 0;
    stall_mode = STALL_NONE;
    send_random_frames(100);
  endtask

  task automatic test_input_backpressure();
    max_gap = 0;
    stall_mode = STALL_PERIODIC;
    hold_req = 1'b1;
    send_random_frames(60);
  endtask

  task automatic test_heavy_stall();
    max_gap = 6;
    stall_mode = STALL_HEAVY;
    send_random_frames(140);
  endtask

  initial begin
    int unsigned waited;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_frames();
    test_full_rate();
    test_input_backpressure();
    test_heavy_stall();
    in_valid <= 1'b0;
    waited = 0;
    while (exp_symbols.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (exp_symbols.size() != 0) begin
      report_fail($sformatf("%0d expected beats never arrived", exp_symbols.size()));
    end
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ word_repack_32_to_24_bitrev.f @@
+incdir+hw/rtl
hw/rtl/wrep_pkg.sv
hw/rtl/wrep_in_reg.sv
hw/rtl/wrep_repack.sv
hw/rtl/wrep_out_buf.sv
hw/rtl/word_repack_32_to_24_bitrev.sv
tb/sv/tb_word_repack_32_to_24_bitrev.sv
